// ===== hdl/mbps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants of the masked byte pattern scanner.
// ----------------------------------------------------------------------------
package mbps_pkg;

    // Pattern bytes held by the configuration registers
    localparam int REG_BYTES         = 16;
    localparam int LEN_BITS          = 5;
    localparam int RESULT_OFS_BITS   = 32;
    localparam int CFG_DATA_BITS     = 64;
    localparam int CFG_INDEX_BITS    = 2;

    localparam int DEF_MAX_PATTERN_BYTES = 16;
    localparam int DEF_OFFSET_BITS       = 32;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_PATTERN_LOW    = 2'd0,
        REG_PATTERN_HIGH   = 2'd1,
        REG_COMPARE_MASK   = 2'd2,
        REG_PATTERN_LENGTH = 2'd3
    } cfg_reg_t;

    typedef logic [REG_BYTES-1:0][7:0] pattern_t;

    typedef struct packed {
        logic                       found;
        logic [RESULT_OFS_BITS-1:0] match_offset;
    } result_t;

endpackage
`default_nettype wire

// ===== hdl/mbps_channels.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbps channels
// Valid/ready channels for scanned bytes and for search results.
// ----------------------------------------------------------------------------
interface mbps_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       section_end;

    modport source (output valid, output data_byte, output section_end, input ready);
    modport sink   (input valid, input data_byte, input section_end, output ready);
endinterface

interface mbps_result_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] match_offset;

    modport source (output valid, output found, output match_offset, input ready);
    modport sink   (input valid, input found, input match_offset, output ready);
endinterface
`default_nettype wire

// ===== hdl/masked_byte_pattern_scanner.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner
// Wildcard byte pattern search over a stream of section bytes.
// ----------------------------------------------------------------------------
// Usage:
//   scan   : one byte word per handshake, section_end on the last byte.
//   result : at most one word per section; found=1 with the start offset of
//            the first match, or found=0 / offset 0 when the section ends
//            without a match.
//   cfg    : pattern bytes, compare mask and length, written while idle.
// Throughput is one byte per cycle while scan ready is high: the byte window
// is a row of cells that shift and compare in parallel, so every accepted
// byte is decided in the cycle it is taken.
// A result word is registered in the result buffer before it is offered.
// A two-entry result buffer lets scanning go on while a result waits; scan
// ready drops only when both entries are held by a stalled receiver.
// Reset clears the window, the byte count and the match flag, loads the
// compare mask with all ones and the other registers with zero.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = DEF_MAX_PATTERN_BYTES,
    parameter int OFFSET_BITS       = DEF_OFFSET_BITS
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    mbps_byte_if.sink                      scan,
    mbps_result_if.source                  result
);

    logic [63:0]          pattern_low_reg;
    logic [63:0]          pattern_high_reg;
    logic [REG_BYTES-1:0] mask_reg;
    logic [LEN_BITS-1:0]  len_reg;

    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic                   matched_reg, matched_next;

    pattern_t pattern;
    logic     accept;
    logic     full;
    logic     counted;
    logic     len_valid;
    logic     hit;
    logic     emit;
    result_t  res;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic [OFFSET_BITS-1:0] start_ofs;

    logic [MAX_PATTERN_BYTES:0][7:0] chain;
    logic [MAX_PATTERN_BYTES-1:0]    cell_ok;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            mask_reg         <= '1;
            len_reg          <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PATTERN_LOW:    pattern_low_reg  <= cfg_data;
                REG_PATTERN_HIGH:   pattern_high_reg <= cfg_data;
                REG_COMPARE_MASK:   mask_reg         <= cfg_data[REG_BYTES-1:0];
                REG_PATTERN_LENGTH: len_reg          <= cfg_data[LEN_BITS-1:0];
            endcase
        end
    end

    assign pattern     = {pattern_high_reg, pattern_low_reg};
    assign accept      = scan.valid && scan.ready;
    assign scan.ready  = !full;

    // window cells
    assign chain[0] = scan.data_byte;

    for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
        mbps_cell #(
            .CELL_INDEX (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (accept),
            .clear    (scan.section_end),
            .byte_in  (chain[k]),
            .pattern  (pattern),
            .mask     (mask_reg),
            .len      (len_reg),
            .byte_out (chain[k+1]),
            .ok       (cell_ok[k])
        );
    end

    // match decision
    assign counted   = (pos_reg != '1);
    assign pos_inc   = pos_reg + OFFSET_BITS'(1);
    assign len_valid = (len_reg != '0) && (len_reg <= LEN_BITS'(REG_BYTES))
                       && (32'(len_reg) <= 32'(MAX_PATTERN_BYTES));
    assign start_ofs = pos_inc - OFFSET_BITS'(len_reg);

    assign hit  = accept && counted && !matched_reg && len_valid
                  && (pos_inc >= OFFSET_BITS'(len_reg)) && (&cell_ok);
    assign emit = hit || (accept && scan.section_end && !matched_reg);

    assign res.found        = hit;
    assign res.match_offset = hit ? RESULT_OFS_BITS'(start_ofs) : '0;

    always_comb
    begin
        pos_next     = pos_reg;
        matched_next = matched_reg;
        if (accept)
        begin
            if (scan.section_end)
            begin
                pos_next     = '0;
                matched_next = 1'b0;
            end
            else
            begin
                if (counted)
                begin
                    pos_next = pos_inc;
                end
                matched_next = matched_reg || hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            matched_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            matched_reg <= matched_next;
        end
    end

    mbps_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (emit),
        .push_data (res),
        .full      (full),
        .result    (result)
    );

    // checks
    a_section_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && scan.section_end) |=> (pos_reg == '0 && !matched_reg))
        else $error("section state not cleared after last byte");

    a_hit_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (hit && !scan.section_end) |=> matched_reg)
        else $error("match flag not set after a found result");

    a_pos_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !scan.section_end) |=> (pos_reg >= $past(pos_reg)))
        else $error("byte position went backward within a section");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !full)
        else $error("result pushed into a full buffer");

endmodule
`default_nettype wire

// ===== hdl/mbps_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbps_cell
// One window position: holds a byte, shifts it on, compares the incoming
// byte with the pattern byte that lines up with this position.
// ----------------------------------------------------------------------------
module mbps_cell
    import mbps_pkg::*;
#(
    parameter int CELL_INDEX = 0
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                shift,
    input  wire logic                clear,
    input  wire logic [7:0]          byte_in,
    input  wire pattern_t            pattern,
    input  wire logic [REG_BYTES-1:0] mask,
    input  wire logic [LEN_BITS-1:0] len,
    output logic      [7:0]          byte_out,
    output logic                     ok
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    generate
        if (CELL_INDEX < REG_BYTES) begin : g_cmp
            logic [LEN_BITS-1:0] pat_idx;
            logic                care;

            // newest byte sits at position 0, so pattern byte len-1-k lands here
            assign pat_idx = len - LEN_BITS'(1) - LEN_BITS'(CELL_INDEX);
            assign care    = (LEN_BITS'(CELL_INDEX) < len) && mask[pat_idx[3:0]];
            assign ok      = !care || (byte_in == pattern[pat_idx[3:0]]);
        end
        else begin : g_nocmp
            assign ok = 1'b1;
        end
    endgenerate

    always_comb
    begin
        byte_next = byte_reg;
        if (shift)
        begin
            byte_next = clear ? 8'd0 : byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'd0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;

endmodule
`default_nettype wire

// ===== hdl/mbps_out_buf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbps_out_buf
// Two-entry result buffer; decouples the scan from a stalled receiver.
// ----------------------------------------------------------------------------
module mbps_out_buf
    import mbps_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         full,
    mbps_result_if.source result
);

    result_t    head_reg, head_next;
    result_t    tail_reg, tail_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign pop          = result.valid && result.ready;
    assign full         = (count_reg == 2'd2);
    assign result.valid = (count_reg != 2'd0);
    assign result.found        = head_reg.found;
    assign result.match_offset = head_reg.match_offset;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        unique case ({push, pop})
            2'b10:
            begin
                if (count_reg == 2'd0)
                begin
                    head_next = push_data;
                end
                else
                begin
                    tail_next = push_data;
                end
                count_next = count_reg + 2'd1;
            end
            2'b01:
            begin
                head_next  = tail_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11:
            begin
                // push only happens when not full
                if (count_reg == 2'd1)
                begin
                    head_next = push_data;
                end
                else
                begin
                    head_next = tail_reg;
                    tail_next = push_data;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule
`default_nettype wire

// ===== tb/masked_byte_pattern_scanner_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_test
// Drives byte sections through the scanner, checks each result word against
// a local model of the wildcard search or a script row. A short scripted
// part covers length zero, overlong lengths, wildcards, match on the last
// byte and sections that are too short. Random phases follow with planted
// patterns, random flow control on both channels and a long receiver hold.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_test;
    import mbps_pkg::*;

    localparam longint unsigned POS_LIMIT = (64'd1 << DEF_OFFSET_BITS) - 64'd1;
    localparam int SCRIPT_ROWS = 25;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD_CYCLES = 300;

    // one scripted step: either a full register load or one byte word
    typedef struct packed {
        bit          is_cfg;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [15:0] msk;
        logic [4:0]  ln;
        logic [7:0]  data_byte;
        bit          last;
        bit          typed;
        bit          t_found;
        logic [31:0] t_offset;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    mbps_byte_if   scan_ch();
    mbps_result_if res_ch();

    masked_byte_pattern_scanner dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .scan      (scan_ch),
        .result    (res_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // model copy of registers and section state
    pattern_t         pat_bytes;
    logic [15:0]      cmp_mask;
    logic [4:0]       pat_len;
    pattern_t         window_bytes;
    longint unsigned  bytes_seen;
    bit               hit_seen;

    result_t          match_reports_due[$];
    result_t          due;
    int               fail_count = 0;
    int               words_sent = 0;

    bit               src_idle_on = 1'b1;
    bit               snk_idle_on = 1'b1;
    bit               quiet = 1'b0;
    bit               hold_request = 1'b0;
    int               hold_left = 0;
    int               stall_left = 0;

    // ---- search model -------------------------------------------------------
    function automatic bit search_step(input logic [7:0] b, input bit last,
                                       output result_t r);
        bit counted;
        bit hit;
        bit ok;
        counted = bytes_seen < POS_LIMIT;
        window_bytes = {window_bytes[REG_BYTES-2:0], b};
        if (counted)
            bytes_seen++;
        hit = 1'b0;
        r = '0;
        if (counted && !hit_seen && pat_len != 0 && pat_len <= REG_BYTES &&
            pat_len <= DEF_MAX_PATTERN_BYTES && bytes_seen >= pat_len)
        begin
            ok = 1'b1;
            for (int j = 0; j < pat_len; j++)
            begin
                if (cmp_mask[j] && window_bytes[pat_len-1-j] != pat_bytes[j])
                    ok = 1'b0;
            end
            if (ok)
            begin
                hit_seen = 1'b1;
                r.found = 1'b1;
                r.match_offset = 32'(bytes_seen - pat_len);
                hit = 1'b1;
            end
        end
        if (last)
        begin
            if (!hit && !hit_seen)
            begin
                r = '0;
                hit = 1'b1;
            end
            window_bytes = '0;
            bytes_seen = 0;
            hit_seen = 1'b0;
        end
        return hit;
    endfunction

    // ---- result side --------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (match_reports_due.size() == 0)
                begin
                    $error("unexpected result word: found=%0d match_offset=%0d",
                           res_ch.found, res_ch.match_offset);
                    fail_count++;
                end
                else
                begin
                    due = match_reports_due.pop_front();
                    if (res_ch.found !== due.found)
                    begin
                        $error("found: expected %0d, got %0d", due.found, res_ch.found);
                        fail_count++;
                    end
                    if (res_ch.match_offset !== due.match_offset)
                    begin
                        $error("match_offset: expected %0d, got %0d",
                               due.match_offset, res_ch.match_offset);
                        fail_count++;
                    end
                end
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else if (snk_idle_on && !quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 14) - 1;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // ---- byte side ----------------------------------------------------------
    task automatic send_word(input logic [7:0] b, input bit last, input bit typed,
                             input result_t typed_res);
        result_t r;
        bit has;
        scan_ch.valid <= 1'b1;
        scan_ch.data_byte <= b;
        scan_ch.section_end <= last;
        @(posedge clk);
        while (!scan_ch.ready)
            @(posedge clk);
        has = search_step(b, last, r);
        if (typed)
            match_reports_due.push_back(typed_res);
        else if (has)
            match_reports_due.push_back(r);
        words_sent++;
        if (src_idle_on && !quiet && $urandom_range(0, 5) == 0)
        begin
            scan_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    // drops valid and waits until every expected result word has been received
    task automatic drain();
        scan_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (match_reports_due.size() != 0);
    endtask

    // idle point: bytes that give no result may still be in the pipe
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_setup(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [15:0] msk, input logic [4:0] ln);
        cfg_we <= 1'b1;
        cfg_index <= REG_PATTERN_LOW;
        cfg_data <= lo;
        @(posedge clk);
        cfg_index <= REG_PATTERN_HIGH;
        cfg_data <= hi;
        @(posedge clk);
        cfg_index <= REG_COMPARE_MASK;
        cfg_data <= {48'd0, msk};
        @(posedge clk);
        cfg_index <= REG_PATTERN_LENGTH;
        cfg_data <= {59'd0, ln};
        @(posedge clk);
        cfg_we <= 1'b0;
        pat_bytes = {hi, lo};
        cmp_mask = msk;
        pat_len = ln;
    endtask

    // one section with random content, pattern copies planted (some broken)
    task automatic run_section(input int n);
        logic [7:0] sec[];
        int p;
        int plants;
        bit bias;
        sec = new[n];
        bias = $urandom_range(0, 1);
        for (int k = 0; k < n; k++)
        begin
            if (bias && $urandom_range(0, 1))
                sec[k] = pat_bytes[$urandom_range(0, REG_BYTES - 1)];
            else
                sec[k] = 8'($urandom);
        end
        plants = $urandom_range(0, 2);
        if (pat_len >= 1 && pat_len <= REG_BYTES && n >= pat_len)
        begin
            for (int i = 0; i < plants; i++)
            begin
                p = $urandom_range(0, n - pat_len);
                for (int j = 0; j < pat_len; j++)
                begin
                    if (cmp_mask[j])
                        sec[p+j] = pat_bytes[j];
                end
                if ($urandom_range(0, 4) == 0)
                    sec[p + $urandom_range(0, pat_len - 1)] ^= 8'(1 << $urandom_range(0, 7));
            end
        end
        for (int k = 0; k < n; k++)
            send_word(sec[k], k == n - 1, 1'b0, '0);
    endtask

    function automatic int section_size();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom_range(1, 20);
        else if (r < 9)
            return $urandom_range(16, 40);
        return $urandom_range(41, 120);
    endfunction

    task automatic random_setup();
        logic [63:0] lo;
        logic [63:0] hi;
        logic [15:0] msk;
        logic [4:0]  ln;
        int r;
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        if ($urandom_range(0, 9) == 0)
            lo = '1;
        r = $urandom_range(0, 9);
        msk = (r < 2) ? 16'hFFFF : (r == 2) ? 16'h0000 : 16'($urandom);
        r = $urandom_range(0, 9);
        if (r == 0)
            ln = 5'd0;
        else if (r == 1)
            ln = 5'($urandom_range(17, 31));
        else if (r < 4)
            ln = 5'd16;
        else
            ln = 5'($urandom_range(1, 15));
        load_setup(lo, hi, msk, ln);
    endtask

    // columns: cfg, pattern_low, pattern_high, mask, length,
    //          byte, section_end, typed, found, offset
    script_row_t script [SCRIPT_ROWS] = '{
        // reset registers: length zero never matches
        '{1'b0, 64'h0, 64'h0, 16'h0, 5'd0, 8'h00, 1'b1, 1'b1, 1'b0, 32'd0},
        '{1'b0, 64'h0, 64'h0, 16'h0, 5'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b0, 64'h0, 64'h0, 16'h0, 5'd0, 8'h80, 1'b1, 1'b1, 1'b0, 32'd0},
        // one byte pattern, later matches ignored, match on last byte
        '{1'b1, 64'hAB, 64'h0, 16'hFFFF, 5'd1, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b0, 64'h0, 64'h0, 16'h0, 5'd0, 8'h12, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b0, 64'h0, 64'h0, 16'h0, 5'd0, 8'hAB, 1'b0, 1'b1, 1'b1, 32'd1},
        '{1'b0, 64'h0, 64'h0, 16'h0, 5'd0, 8'hAB, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b0, 64'h0, 64'h0, 16'h0, 5'd0, 8'h01, 1'b1, 1'b0, 1'b0, 32'd0},
        '{1'b0, 64'h0, 64'h0, 16'h0, 5'd0, 8'hAB, 1'b1, 1'b1, 1'b1, 32'd0},
        // wildcards at both ends, mask bits above length set
        '{1'b1, 64'h00FF_7F00, 64'h0, 16'hFFFA, 5'd3, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b0, 64'h0, 64'h0, 16'h0, 5'd0, 8'h55, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b0, 64'h0, 64'h0, 16'h0, 5'd0, 8'h7F, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b0, 64'h0, 64'h0, 16'h0, 5'd0, 8'hAA, 1'b0, 1'b1, 1'b1, 32'd0},
        '{1'b0, 64'h0, 64'h0, 16'h0, 5'd0, 8'h00, 1'b1, 1'b0, 1'b0, 32'd0},
        // section shorter than pattern
        '{1'b0, 64'h0, 64'h0, 16'h0, 5'd0, 8'h7F, 1'b1, 1'b1, 1'b0, 32'd0},
        // overlong lengths never match
        '{1'b1, '1, '1, 16'h0000, 5'd31, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b0, 64'h0, 64'h0, 16'h0, 5'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b0, 64'h0, 64'h0, 16'h0, 5'd0, 8'hFF, 1'b1, 1'b1, 1'b0, 32'd0},
        '{1'b1, 64'h0, 64'h0, 16'hFFFF, 5'd17, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b0, 64'h0, 64'h0, 16'h0, 5'd0, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b0, 64'h0, 64'h0, 16'h0, 5'd0, 8'h00, 1'b1, 1'b1, 1'b0, 32'd0},
        // all wildcards
        '{1'b1, 64'h0, '1, 16'h0000, 5'd2, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b0, 64'h0, 64'h0, 16'h0, 5'd0, 8'h3C, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b0, 64'h0, 64'h0, 16'h0, 5'd0, 8'hC3, 1'b0, 1'b1, 1'b1, 32'd0},
        '{1'b0, 64'h0, 64'h0, 16'h0, 5'd0, 8'h00, 1'b1, 1'b0, 1'b0, 32'd0}
    };

    initial
    begin
        int phase;
        int nsec;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_PATTERN_LOW;
        cfg_data = '0;
        scan_ch.valid = 1'b0;
        scan_ch.data_byte = 8'h00;
        scan_ch.section_end = 1'b0;
        res_ch.ready = 1'b0;
        pat_bytes = '0;
        cmp_mask = 16'hFFFF;
        pat_len = 5'd0;
        window_bytes = '0;
        bytes_seen = 0;
        hit_seen = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].is_cfg)
            begin
                settle();
                load_setup(script[i].lo, script[i].hi, script[i].msk, script[i].ln);
            end
            else
                send_word(script[i].data_byte, script[i].last, script[i].typed,
                          {script[i].t_found, script[i].t_offset});
        end

        phase = 0;
        while (words_sent < 1500)
        begin
            settle();
            src_idle_on = $urandom_range(0, 3) != 0;
            snk_idle_on = $urandom_range(0, 3) != 0;
            if (phase == 0)
                load_setup('1, '1, 16'hFFFF, 5'd16);
            else if (phase == 1)
                load_setup('0, '0, 16'h0000, 5'd16);
            else if (phase == 2)
                load_setup({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom), 5'd31);
            else if (phase == 3)
                load_setup(64'($urandom_range(0, 255)), '0, 16'hFFFF, 5'd1);
            else
                random_setup();
            if (phase == 3)
            begin
                // every one-byte section gives a word; the hold backs up the scan side
                hold_request = 1'b1;
                for (int s = 0; s < 40; s++)
                    run_section(1);
            end
            else
            begin
                nsec = $urandom_range(4, 10);
                for (int s = 0; s < nsec; s++)
                begin
                    if (phase == 5 && s == nsec / 2)
                        drain();
                    run_section(section_size());
                end
            end
            phase++;
        end

        // closing stretch at full rate on both sides
        settle();
        quiet = 1'b1;
        random_setup();
        while (words_sent < 1700)
            run_section(section_size());

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/mbps_pkg.sv
hdl/mbps_channels.sv
hdl/mbps_cell.sv
hdl/mbps_out_buf.sv
hdl/masked_byte_pattern_scanner.sv
tb/masked_byte_pattern_scanner_test.sv
